### hw/rtl/trcc_pkg.sv
// Shared types, constants and helpers of the TCP Reno ACK congestion control block.
package trcc_pkg;

    localparam int WINDOW_BITS_DEFAULT = 16;

    localparam logic [15:0] DUP_THRESHOLD  = 16'd3;
    localparam logic [15:0] MAX16          = 16'hFFFF;

    localparam logic [15:0] MSS_RESET      = 16'd1460;
    localparam logic [15:0] CWND_RESET     = 16'd1;
    localparam logic [15:0] SSTHRESH_RESET = 16'd16;
    localparam logic [31:0] START_RESET    = 32'd0;

    localparam int CFG_INDEX_BITS = 8;
    localparam int CFG_DATA_BITS  = 32;
    localparam int IN_DATA_BITS   = 152;
    localparam int OUT_DATA_BITS  = 88;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_MAX_SEGMENT_SIZE = 8'd0,
        CFG_INITIAL_CWND     = 8'd1,
        CFG_INITIAL_SSTHRESH = 8'd2,
        CFG_SEND_START_SEQ   = 8'd3
    } cfg_index_t;

    // Input beat, first field in the lowest bits
    typedef struct packed {
        logic [5:0]  pad;
        logic        listening;
        logic [31:0] send_next;
        logic [15:0] peer_window;
        logic [31:0] seg_seq_end;
        logic [31:0] seg_seq;
        logic [31:0] ack_num;
        logic        ack_flag;
    } in_item_t;

    // Result beat, first field in the lowest bits
    typedef struct packed {
        logic [2:0]  pad;
        logic        in_recovery;
        logic        send_ack;
        logic        stop_timer;
        logic        restart_timer;
        logic        retransmit;
        logic [15:0] send_window;
        logic [15:0] slow_start_limit;
        logic [15:0] cong_window;
        logic [31:0] unacked_seq;
    } out_item_t;

    // True when a comes before b in modulo 2^32 sequence space
    function automatic logic seq_before(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] diff;
        diff = a - b;
        return diff[31];
    endfunction

    function automatic logic [15:0] inc_sat16(input logic [15:0] v);
        return (v == MAX16) ? v : v + 16'd1;
    endfunction

endpackage

### hw/rtl/tcp_reno_ack_congestion_control.sv
// TCP Reno ACK-side congestion control: one ACK segment in, one window update out.
//
//  channel   ports                                   beat
//  -------   -------------------------------------   --------------------------------
//  input     s_tvalid s_tready s_tdata[151:0]        one received segment's ACK info
//  result    m_tvalid m_tready m_tdata[87:0]         window, threshold and timer flags
//  config    cfg_valid cfg_ready cfg_index cfg_data  register write, always ready
//
// One beat per cycle while the result is not stalled; a beat goes into the input register,
// then one pass of compare, multiply and select writes the result register on m_tdata.
// The multiply cwnd * max_segment_size sets the critical path.
// Synchronous active-low reset loads mss 1460, cwnd 1, ssthresh 16, unacked 0.
// A stalled result holds; the input register still takes one beat if empty, then holds too.
module tcp_reno_ack_congestion_control #(
    parameter int WINDOW_BITS = trcc_pkg::WINDOW_BITS_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_tvalid,
    output logic                                s_tready,
    // ack_flag, ack_num, seg_seq, seg_seq_end, peer_window, send_next, listening, zero pad
    input  logic [trcc_pkg::IN_DATA_BITS-1:0]   s_tdata,

    output logic                                m_tvalid,
    input  logic                                m_tready,
    // unacked_seq, cong_window, slow_start_limit, send_window, retransmit,
    // restart_timer, stop_timer, send_ack, in_recovery, zero pad
    output logic [trcc_pkg::OUT_DATA_BITS-1:0]  m_tdata,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [trcc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [trcc_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    localparam logic [32:0] WMAX_WIDE = (33'd1 << WINDOW_BITS) - 33'd1;
    localparam logic [31:0] WMAX      = WMAX_WIDE[31:0];

    logic                in_valid_reg;
    trcc_pkg::in_item_t  in_item_reg;
    logic                out_valid_reg;
    trcc_pkg::out_item_t out_item_reg;
    trcc_pkg::out_item_t out_item_next;

    logic [15:0] mss_reg;
    logic [31:0] unacked_reg,  unacked_next;
    logic [15:0] cwnd_reg,     cwnd_next;
    logic [15:0] ssthresh_reg, ssthresh_next;
    logic [15:0] avoid_reg,    avoid_next;
    logic [15:0] dup_reg,      dup_next;
    logic [31:0] recovery_reg, recovery_next;

    logic        advance;
    logic        fire;
    logic        in_accept;
    logic        cfg_write;
    logic        retransmit;
    logic        restart_timer;
    logic        stop_timer;
    logic [15:0] avoid_inc;
    logic [15:0] half_cwnd;
    logic [15:0] new_ssthresh;
    logic [31:0] product;
    logic [31:0] product_sat;
    logic [31:0] peer_masked;
    logic [31:0] window_min;

    assign advance   = !out_valid_reg || m_tready;
    assign fire      = in_valid_reg && advance;
    assign s_tready  = !in_valid_reg || advance;
    assign in_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_item_reg;

    // Congestion state update for the beat in the input register
    always_comb begin
        unacked_next  = unacked_reg;
        cwnd_next     = cwnd_reg;
        ssthresh_next = ssthresh_reg;
        avoid_next    = avoid_reg;
        dup_next      = dup_reg;
        recovery_next = recovery_reg;
        retransmit    = 1'b0;
        restart_timer = 1'b0;
        stop_timer    = 1'b0;
        avoid_inc     = trcc_pkg::inc_sat16(avoid_reg);
        half_cwnd     = {1'b0, cwnd_reg[15:1]};
        new_ssthresh  = (half_cwnd == 16'd0) ? 16'd1 : half_cwnd;
        if (in_item_reg.ack_flag) begin
            if (trcc_pkg::seq_before(unacked_reg, in_item_reg.ack_num)) begin
                unacked_next = in_item_reg.ack_num;
                if (dup_reg >= trcc_pkg::DUP_THRESHOLD) begin
                    // leave recovery once the recovery point is covered
                    if (!trcc_pkg::seq_before(in_item_reg.ack_num, recovery_reg)) begin
                        dup_next = 16'd0;
                    end
                end else if (cwnd_reg < ssthresh_reg) begin
                    cwnd_next = trcc_pkg::inc_sat16(cwnd_reg);
                end else if (avoid_inc >= cwnd_reg) begin
                    cwnd_next  = trcc_pkg::inc_sat16(cwnd_reg);
                    avoid_next = 16'd0;
                end else begin
                    avoid_next = avoid_inc;
                end
                if (in_item_reg.ack_num == in_item_reg.send_next) begin
                    stop_timer = 1'b1;
                end else begin
                    restart_timer = 1'b1;
                    retransmit    = (dup_next >= trcc_pkg::DUP_THRESHOLD);
                end
            end else begin
                dup_next = trcc_pkg::inc_sat16(dup_reg);
                // third duplicate: halve and enter fast recovery
                if (dup_reg == trcc_pkg::DUP_THRESHOLD - 16'd1) begin
                    ssthresh_next = new_ssthresh;
                    cwnd_next     = new_ssthresh;
                    recovery_next = in_item_reg.send_next;
                    retransmit    = 1'b1;
                end
            end
        end
    end

    // Send window: min(peer window, cwnd * mss), both clipped to the window width
    always_comb begin
        product     = 32'(cwnd_next) * 32'(mss_reg);
        product_sat = (product > WMAX) ? WMAX : product;
        peer_masked = {16'd0, in_item_reg.peer_window} & WMAX;
        window_min  = (product_sat < peer_masked) ? product_sat : peer_masked;
    end

    always_comb begin
        out_item_next                  = '0;
        out_item_next.unacked_seq      = unacked_next;
        out_item_next.cong_window      = cwnd_next;
        out_item_next.slow_start_limit = ssthresh_next;
        out_item_next.send_window      = window_min[15:0];
        out_item_next.retransmit       = retransmit;
        out_item_next.restart_timer    = restart_timer;
        out_item_next.stop_timer       = stop_timer;
        out_item_next.send_ack         = !in_item_reg.listening &&
            trcc_pkg::seq_before(in_item_reg.seg_seq, in_item_reg.seg_seq_end);
        out_item_next.in_recovery      = (dup_next >= trcc_pkg::DUP_THRESHOLD);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_accept) begin
                in_valid_reg <= 1'b1;
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end
            if (fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: input loads on accept, result loads on fire, both hold otherwise
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            in_item_reg <= trcc_pkg::in_item_t'(s_tdata);
        end
        if (fire) begin
            out_item_reg <= out_item_next;
        end
    end

    // Congestion state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mss_reg      <= trcc_pkg::MSS_RESET;
            unacked_reg  <= trcc_pkg::START_RESET;
            cwnd_reg     <= trcc_pkg::CWND_RESET;
            ssthresh_reg <= trcc_pkg::SSTHRESH_RESET;
            avoid_reg    <= 16'd0;
            dup_reg      <= 16'd0;
            recovery_reg <= 32'd0;
        end else if (cfg_write) begin
            case (cfg_index)
                trcc_pkg::CFG_MAX_SEGMENT_SIZE: mss_reg      <= cfg_data[15:0];
                trcc_pkg::CFG_INITIAL_CWND:     cwnd_reg     <= cfg_data[15:0];
                trcc_pkg::CFG_INITIAL_SSTHRESH: ssthresh_reg <= cfg_data[15:0];
                trcc_pkg::CFG_SEND_START_SEQ:   unacked_reg  <= cfg_data;
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end else if (fire) begin
            unacked_reg  <= unacked_next;
            cwnd_reg     <= cwnd_next;
            ssthresh_reg <= ssthresh_next;
            avoid_reg    <= avoid_next;
            dup_reg      <= dup_next;
            recovery_reg <= recovery_next;
        end
    end

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the TCP Reno ACK congestion control block.
module testbench;

    localparam int PHASES           = 5;
    localparam int RANDOM_PER_PHASE = 306;
    localparam int DRAIN_CYCLES     = 8;
    localparam int STALL_LIMIT      = 2000;
    localparam int MAX_REPORTS      = 100;
    localparam int WIN_BITS         = trcc_pkg::WINDOW_BITS_DEFAULT;
    localparam logic [trcc_pkg::CFG_INDEX_BITS-1:0] CFG_UNUSED_INDEX = 8'd4;

    typedef struct packed {
        bit [31:0] unacked;
        bit [15:0] cwnd;
        bit [15:0] ssthresh;
        bit [15:0] avoid_cnt;
        bit [15:0] dups;
        bit [31:0] recover_seq;
    } reno_state_t;

    logic                                aclk      = 1'b0;
    logic                                aresetn   = 1'b0;
    logic                                s_tvalid  = 1'b0;
    logic                                s_tready;
    trcc_pkg::in_item_t                  s_beat    = '0;
    logic                                m_tvalid;
    logic                                m_tready  = 1'b0;
    trcc_pkg::out_item_t                 m_beat;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [trcc_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [trcc_pkg::CFG_DATA_BITS-1:0]  cfg_data  = '0;

    reno_state_t          cc_state;
    reno_state_t          gen_state;
    bit [15:0]            seg_size;
    bit [31:0]            flight_end;
    int unsigned          dup_run;
    trcc_pkg::in_item_t   ack_segments[$];
    trcc_pkg::out_item_t  expected_updates[$];
    int unsigned          send_idle_pct = 0;
    int unsigned          recv_idle_pct = 0;
    int unsigned          stall_cycles  = 0;
    int                   error_count   = 0;
    int                   result_count  = 0;

    tcp_reno_ack_congestion_control dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_beat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_beat),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic bit seq_older(input bit [31:0] a, input bit [31:0] b);
        bit [31:0] diff;
        diff = a - b;
        return diff[31];
    endfunction

    function automatic bit [15:0] sat_inc16(input bit [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    // Apply one ACK segment to the window state and return the update it causes.
    function automatic trcc_pkg::out_item_t reno_ack_update(inout reno_state_t st,
                                                            input trcc_pkg::in_item_t seg,
                                                            input bit [15:0] mss);
        trcc_pkg::out_item_t r;
        bit [15:0] prev_dups;
        bit [15:0] half;
        bit [63:0] wmax;
        bit [63:0] prod;
        bit [63:0] win;
        r = '0;
        wmax = (64'd1 << WIN_BITS) - 64'd1;
        if (seg.ack_flag) begin
            if (seq_older(st.unacked, seg.ack_num)) begin
                st.unacked = seg.ack_num;
                if (st.dups >= trcc_pkg::DUP_THRESHOLD) begin
                    // leave recovery only once the recovery point is covered
                    if (!seq_older(seg.ack_num, st.recover_seq))
                        st.dups = 16'd0;
                end else if (st.cwnd < st.ssthresh) begin
                    st.cwnd = sat_inc16(st.cwnd);
                end else begin
                    st.avoid_cnt = sat_inc16(st.avoid_cnt);
                    if (st.avoid_cnt >= st.cwnd) begin
                        st.cwnd = sat_inc16(st.cwnd);
                        st.avoid_cnt = 16'd0;
                    end
                end
                if (st.unacked == seg.send_next) begin
                    r.stop_timer = 1'b1;
                end else begin
                    r.restart_timer = 1'b1;
                    if (st.dups >= trcc_pkg::DUP_THRESHOLD)
                        r.retransmit = 1'b1;
                end
            end else begin
                prev_dups = st.dups;
                st.dups = sat_inc16(st.dups);
                if (st.dups == trcc_pkg::DUP_THRESHOLD && prev_dups != st.dups) begin
                    half = st.cwnd >> 1;
                    st.ssthresh = (half == 16'd0) ? 16'd1 : half;
                    st.cwnd = st.ssthresh;
                    st.recover_seq = seg.send_next;
                    r.retransmit = 1'b1;
                end
            end
        end
        prod = {48'd0, st.cwnd} * {48'd0, mss};
        if (prod > wmax)
            prod = wmax;
        win = {48'd0, seg.peer_window} & wmax;
        if (prod < win)
            win = prod;
        r.unacked_seq      = st.unacked;
        r.cong_window      = st.cwnd;
        r.slow_start_limit = st.ssthresh;
        r.send_window      = win[15:0];
        r.send_ack         = !seg.listening && seq_older(seg.seg_seq, seg.seg_seq_end);
        r.in_recovery      = (st.dups >= trcc_pkg::DUP_THRESHOLD);
        return r;
    endfunction

    function automatic void apply_reg_write(input logic [trcc_pkg::CFG_INDEX_BITS-1:0] idx,
                                            input logic [trcc_pkg::CFG_DATA_BITS-1:0] value);
        case (idx)
            trcc_pkg::CFG_MAX_SEGMENT_SIZE: seg_size = value[15:0];
            trcc_pkg::CFG_INITIAL_CWND:     cc_state.cwnd = value[15:0];
            trcc_pkg::CFG_INITIAL_SSTHRESH: cc_state.ssthresh = value[15:0];
            trcc_pkg::CFG_SEND_START_SEQ:   cc_state.unacked = value;
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        if (error_count < MAX_REPORTS)
            $display("ERROR at result %0d: %s", result_count, msg);
        error_count++;
    endtask

    task automatic check_update(input trcc_pkg::out_item_t got,
                                input trcc_pkg::out_item_t want);
        if (got.unacked_seq !== want.unacked_seq)
            report_mismatch($sformatf("unacked_seq %h, expected %h",
                                      got.unacked_seq, want.unacked_seq));
        if (got.cong_window !== want.cong_window)
            report_mismatch($sformatf("cong_window %h, expected %h",
                                      got.cong_window, want.cong_window));
        if (got.slow_start_limit !== want.slow_start_limit)
            report_mismatch($sformatf("slow_start_limit %h, expected %h",
                                      got.slow_start_limit, want.slow_start_limit));
        if (got.send_window !== want.send_window)
            report_mismatch($sformatf("send_window %h, expected %h",
                                      got.send_window, want.send_window));
        if (got.retransmit !== want.retransmit)
            report_mismatch($sformatf("retransmit %b, expected %b",
                                      got.retransmit, want.retransmit));
        if (got.restart_timer !== want.restart_timer)
            report_mismatch($sformatf("restart_timer %b, expected %b",
                                      got.restart_timer, want.restart_timer));
        if (got.stop_timer !== want.stop_timer)
            report_mismatch($sformatf("stop_timer %b, expected %b",
                                      got.stop_timer, want.stop_timer));
        if (got.send_ack !== want.send_ack)
            report_mismatch($sformatf("send_ack %b, expected %b",
                                      got.send_ack, want.send_ack));
        if (got.in_recovery !== want.in_recovery)
            report_mismatch($sformatf("in_recovery %b, expected %b",
                                      got.in_recovery, want.in_recovery));
        if (got.pad !== want.pad)
            report_mismatch($sformatf("pad %b, expected %b", got.pad, want.pad));
    endtask

    task automatic push_segment(input bit ackf, input bit [31:0] ack, input bit [31:0] seq,
                                input bit [31:0] seq_end, input bit [15:0] peer_win,
                                input bit [31:0] nxt, input bit listen);
        trcc_pkg::in_item_t seg;
        seg = '0;
        seg.ack_flag    = ackf;
        seg.ack_num     = ack;
        seg.seg_seq     = seq;
        seg.seg_seq_end = seq_end;
        seg.peer_window = peer_win;
        seg.send_next   = nxt;
        seg.listening   = listen;
        ack_segments.push_back(seg);
    endtask

    // Build ACK streams that track the sender: advances, duplicate runs, partial ACKs, noise.
    task automatic queue_segments(input int count);
        trcc_pkg::in_item_t seg;
        bit [31:0]          span;
        bit [31:0]          lim;
        int unsigned        pick;
        for (int i = 0; i < count; i++) begin
            seg = '0;
            if (!seq_older(gen_state.unacked, flight_end))
                flight_end = gen_state.unacked + $urandom_range(1, 20000);
            if ($urandom_range(0, 3) == 0)
                flight_end += $urandom_range(0, 3000);
            span = flight_end - gen_state.unacked;
            lim = (span > 32'd3000) ? 32'd3000 : span;
            seg.ack_flag  = 1'b1;
            seg.send_next = flight_end;
            pick = $urandom_range(0, 99);
            if (dup_run != 0) begin
                dup_run--;
                seg.ack_num = gen_state.unacked;
            end else if (pick < 30) begin
                seg.ack_num = gen_state.unacked + $urandom_range(1, lim);
            end else if (pick < 45) begin
                seg.ack_num = gen_state.unacked + $urandom_range(1, span);
            end else if (pick < 55) begin
                seg.ack_num = flight_end;
            end else if (pick < 65) begin
                seg.ack_num = gen_state.unacked;
            end else if (pick < 77) begin
                dup_run = $urandom_range(2, 5);
                seg.ack_num = gen_state.unacked;
            end else if (pick < 82) begin
                seg.ack_num = gen_state.unacked - $urandom_range(1, 50000);
            end else if (pick < 88) begin
                seg.ack_flag = 1'b0;
                seg.ack_num = $urandom;
            end else begin
                seg.ack_flag  = 1'($urandom_range(0, 1));
                seg.ack_num   = $urandom;
                seg.send_next = $urandom;
            end
            seg.seg_seq = $urandom;
            case ($urandom_range(0, 3))
                0:       seg.seg_seq_end = seg.seg_seq;
                1:       seg.seg_seq_end = seg.seg_seq + $urandom_range(1, 1460);
                2:       seg.seg_seq_end = seg.seg_seq - $urandom_range(1, 1460);
                default: seg.seg_seq_end = $urandom;
            endcase
            case ($urandom_range(0, 7))
                0:       seg.peer_window = 16'd0;
                1:       seg.peer_window = 16'hFFFF;
                default: seg.peer_window = 16'($urandom_range(0, 65535));
            endcase
            seg.listening = ($urandom_range(0, 9) == 0);
            void'(reno_ack_update(gen_state, seg, seg_size));
            ack_segments.push_back(seg);
        end
    endtask

    task automatic write_reg(input logic [trcc_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [trcc_pkg::CFG_DATA_BITS-1:0] value);
        @(posedge aclk);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk);
        while (cfg_ready !== 1'b1);
        apply_reg_write(idx, value);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(posedge aclk);
        while (ack_segments.size() != 0 || expected_updates.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Driver: a segment leaves the queue only when its beat is accepted.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_updates.push_back(reno_ack_update(cc_state, s_beat, seg_size));
                void'(ack_segments.pop_front());
            end
            if (!s_tvalid || s_tready) begin
                if (ack_segments.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_beat   <= ack_segments[0];
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_updates.size() == 0)
                    report_mismatch($sformatf("unexpected result beat %h", m_beat));
                else
                    check_update(m_beat, expected_updates.pop_front());
                result_count++;
            end
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("tcp_reno_ack_congestion_control test failed");
        $finish;
    end

    initial begin
        bit [15:0] mss_plan   [PHASES];
        bit [15:0] cwnd_plan  [PHASES];
        bit [15:0] ssth_plan  [PHASES];
        bit [31:0] start_plan [PHASES];

        cc_state = '{unacked: trcc_pkg::START_RESET, cwnd: trcc_pkg::CWND_RESET,
                     ssthresh: trcc_pkg::SSTHRESH_RESET, avoid_cnt: 16'd0, dups: 16'd0,
                     recover_seq: 32'd0};
        seg_size = trcc_pkg::MSS_RESET;
        mss_plan   = '{16'd1, 16'hFFFF, 16'd1460, 16'd1, 16'd536};
        cwnd_plan  = '{16'd1, 16'hFFFF, 16'd10, 16'd1, 16'd2};
        ssth_plan  = '{16'd1, 16'hFFFF, 16'hFFFF, 16'd1, 16'd4};
        start_plan = '{32'hFFFF_FFFF, 32'h7FFF_FFF0, 32'd0, 32'd0, 32'h8000_0000};
        mss_plan[3]   = 16'($urandom_range(1, 65535));
        cwnd_plan[3]  = 16'($urandom_range(1, 64));
        ssth_plan[3]  = 16'($urandom_range(1, 128));
        start_plan[2] = $urandom;
        start_plan[3] = $urandom;
        send_idle_pct = 33;
        recv_idle_pct = 47;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed run on reset values: no-ACK segments, slow start, buffer clear,
        // third duplicate with halving to the floor, partial and full ACK in recovery,
        // stale ACK, half-space jumps and wrapped segment bounds.
        push_segment(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
                     32'hFFFF_FFFF, 1'b1);
        push_segment(1'b0, 32'd0, 32'd0, 32'd0, 16'd0, 32'd0, 1'b0);
        push_segment(1'b1, 32'd1000, 32'd0, 32'd1460, 16'd0, 32'd5000, 1'b0);
        push_segment(1'b1, 32'd5000, 32'd100, 32'd50, 16'hFFFF, 32'd5000, 1'b0);
        repeat (4)
            push_segment(1'b1, 32'd5000, 32'd5000, 32'd6000, 16'hFFFF, 32'd20000, 1'b0);
        push_segment(1'b1, 32'd8000, 32'd0, 32'd1, 16'd3000, 32'd20000, 1'b0);
        push_segment(1'b1, 32'd20000, 32'd0, 32'd1, 16'd3000, 32'd20000, 1'b0);
        push_segment(1'b1, 32'd100, 32'd0, 32'd1, 16'd3000, 32'd20000, 1'b0);
        push_segment(1'b1, 32'd20000 + 32'h7FFF_FFFF, 32'd0, 32'd1, 16'hFFFF,
                     32'd20000 + 32'h8000_0010, 1'b0);
        push_segment(1'b1, 32'd20000 + 32'h7FFF_FFFF + 32'h8000_0000, 32'd0, 32'd1,
                     16'hFFFF, 32'd20000 + 32'h7FFF_FFFF + 32'h8000_0000, 1'b0);
        push_segment(1'b0, 32'd0, 32'hFFFF_FFF0, 32'd10, 16'd1234, 32'd0, 1'b0);
        push_segment(1'b0, 32'd0, 32'hFFFF_FFF0, 32'd10, 16'd1234, 32'd0, 1'b1);
        wait_drained();

        for (int p = 0; p < PHASES; p++) begin
            if (p == 2) begin
                send_idle_pct = 47;
                recv_idle_pct = 33;
            end else if (p == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_reg(trcc_pkg::CFG_MAX_SEGMENT_SIZE, {16'd0, mss_plan[p]});
            write_reg(trcc_pkg::CFG_INITIAL_CWND, {16'd0, cwnd_plan[p]});
            write_reg(trcc_pkg::CFG_INITIAL_SSTHRESH, {16'd0, ssth_plan[p]});
            write_reg(trcc_pkg::CFG_SEND_START_SEQ, start_plan[p]);
            if (p == 0)
                write_reg(CFG_UNUSED_INDEX, 32'hDEAD_BEEF);
            gen_state  = cc_state;
            flight_end = cc_state.unacked;
            dup_run    = 0;
            queue_segments(RANDOM_PER_PHASE / 2);
            // hold the sender until every update is back
            wait_drained();
            queue_segments(RANDOM_PER_PHASE - RANDOM_PER_PHASE / 2);
            wait_drained();
        end

        if (expected_updates.size() != 0)
            report_mismatch($sformatf("%0d updates never arrived", expected_updates.size()));
        if (error_count == 0)
            $display("tcp_reno_ack_congestion_control test passed");
        else
            $display("tcp_reno_ack_congestion_control test failed");
        $finish;
    end

endmodule

### sim.f
hw/rtl/trcc_pkg.sv
hw/rtl/tcp_reno_ack_congestion_control.sv
dv/testbench.sv
